>>> design/bmp_pixel_to_rgba_converter_defines.svh
// Assertion macros for the BMP pixel to RGBA converter.
`ifndef BMP_PIXEL_TO_RGBA_CONVERTER_DEFINES_SVH
`define BMP_PIXEL_TO_RGBA_CONVERTER_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define BMPC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BMPC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> design/bmpc_pkg.sv
// Shared types, codes and helpers for the BMP pixel to RGBA converter.
`timescale 1ns / 1ps

package bmpc_pkg;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 15;
  localparam int DIM_CFG_W   = 15;
  localparam int MODE_W      = 3;
  localparam int COUNT_W     = 9;
  localparam int SLOT_W      = 8;
  localparam int RGB_W       = 24;
  localparam int BYTE_W      = 8;
  localparam int XY_W        = 14;
  localparam int GATHER_W    = 24;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 64;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_PIXEL_MODE    = 3'd2,
    REG_ROWS_TOP_DOWN = 3'd3,
    REG_PALETTE_COUNT = 3'd4
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_4BPP  = 3'd0,
    MODE_8BPP  = 3'd1,
    MODE_16BPP = 3'd2,
    MODE_24BPP = 3'd3,
    MODE_32BPP = 3'd4
  } pixel_mode_t;

  localparam logic ACT_PALETTE = 1'b0;
  localparam logic ACT_DATA    = 1'b1;

  localparam logic [MODE_W-1:0]  MODE_RESET  = 3'd1;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;
  localparam logic [BYTE_W-1:0]  ALPHA_OPAQUE = 8'hff;

  typedef struct packed {
    logic [BYTE_W-1:0] alpha;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
  } rgba_t;

  function automatic logic [BYTE_W-1:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic rgba_t from_rgb(input logic [RGB_W-1:0] c);
    rgba_t p;
    p.alpha = ALPHA_OPAQUE;
    p.red   = c[23:16];
    p.green = c[15:8];
    p.blue  = c[7:0];
    return p;
  endfunction

endpackage

>>> design/bmpc_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
`timescale 1ns / 1ps

module bmpc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> design/bmp_pixel_to_rgba_converter.sv
// Top level: BMP uncompressed pixel array to RGBA pixel stream converter.
`timescale 1ns / 1ps
`include "bmp_pixel_to_rgba_converter_defines.svh"

// Takes one request per cycle while in_tready is high: palette writes (tuser 0) and
// image bytes in file order (tuser 1), row padding included. 8, 16, 24 and 32 bpp
// sustain one byte per cycle while out_tready is high; a 4 bpp byte with two pixels
// holds the input until its second pixel moves on, as the output register emits one
// pixel per cycle. Palette colors come from a RAM with registered read, two read ports
// (one per nibble); a pixel passes the holding stage, then the output register. Palette
// writes land at once; the palette has no reset and needs no clearing pass. A write to a
// defined config register restarts the position at the first image byte, keeps the palette.
module bmp_pixel_to_rgba_converter #(
  parameter int MAX_DIMENSION = 16384,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bmpc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [bmpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] palette_slot, [31:8] palette_rgb, [39:32] data_byte
  input  logic [bmpc_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] action
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [45:32] pixel_x,
  // [59:46] pixel_y, [63:60] zero
  output logic [bmpc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast
);

  localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
  localparam int RS_W   = DIM_W + 2;
  localparam int CW     = (DIM_W > bmpc_pkg::DIM_CFG_W) ? DIM_W : bmpc_pkg::DIM_CFG_W;
  localparam int PAL_AW = $clog2(PALETTE_DEPTH);
  localparam int XY_W   = bmpc_pkg::XY_W;
  localparam int BW     = bmpc_pkg::BYTE_W;

  // configuration
  logic [DIM_W-1:0]                 w_r, h_r;
  logic [bmpc_pkg::MODE_W-1:0]      mode_r;
  logic                             top_down_r;
  logic [bmpc_pkg::COUNT_W-1:0]     pal_count_r;
  logic [CW-1:0]                    cfg_dim;
  logic [DIM_W-1:0]                 cfg_dim_clamped;
  logic                             cfg_hit;

  // position
  logic [DIM_W-1:0]                 col_r, col_nxt, row_r, row_nxt;
  logic [RS_W-1:0]                  bir_r, bir_nxt, row_size;
  logic [RS_W:0]                    bir_inc;
  logic [1:0]                       bip_r, bip_nxt;
  logic [bmpc_pkg::GATHER_W-1:0]    gather_r, gather_nxt;

  // step decode
  logic [BW-1:0]                    in_byte;
  logic [bmpc_pkg::SLOT_W-1:0]      in_slot;
  logic [bmpc_pkg::RGB_W-1:0]       in_rgb;
  logic                             accept, data_acc, mode_ok;
  logic [RS_W-1:0]                  w_e;
  logic [DIM_W:0]                   col_p1;
  logic [DIM_W-1:0]                 w_m1, h_m1, y_dim;
  logic                             emit_a, emit_b, a_pal;
  bmpc_pkg::rgba_t                  a_rgba;
  logic [BW-1:0]                    idx_a, idx_b;
  logic [bmpc_pkg::COUNT_W-1:0]     cnt_eff;
  logic [PAL_AW-1:0]                raddr_a, raddr_b;
  logic                             pal_we, s1_load;
  logic [bmpc_pkg::RGB_W-1:0]       ram_a, ram_b;

  // result holding stage
  logic                             a_pend_r, b_pend_r, a_pal_r;
  bmpc_pkg::rgba_t                  a_rgba_r;
  logic [XY_W-1:0]                  a_x_r, b_x_r, y_r;
  logic                             a_last_r, b_last_r;
  logic                             s1_valid, move, s1_free;
  bmpc_pkg::rgba_t                  mv_rgba;
  logic [XY_W-1:0]                  mv_x;
  logic                             mv_last;

  // output register
  logic                             out_v_r;
  logic [bmpc_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                             out_last_r;

  assign in_slot = in_tdata[7:0];
  assign in_rgb  = in_tdata[31:8];
  assign in_byte = in_tdata[39:32];

  // configuration write
  assign cfg_dim = CW'(cfg_wdata[bmpc_pkg::DIM_CFG_W-1:0]);
  assign cfg_dim_clamped = (cfg_dim == '0) ? DIM_W'(1) :
                           (cfg_dim > CW'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) :
                           DIM_W'(cfg_dim);

  always_comb begin
    unique case (cfg_addr)
      bmpc_pkg::REG_IMAGE_WIDTH,
      bmpc_pkg::REG_IMAGE_HEIGHT,
      bmpc_pkg::REG_PIXEL_MODE,
      bmpc_pkg::REG_ROWS_TOP_DOWN,
      bmpc_pkg::REG_PALETTE_COUNT: cfg_hit = cfg_we;
      default:                     cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= DIM_W'(1);
      h_r         <= DIM_W'(1);
      mode_r      <= bmpc_pkg::MODE_RESET;
      top_down_r  <= 1'b0;
      pal_count_r <= bmpc_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bmpc_pkg::REG_IMAGE_WIDTH:   w_r <= cfg_dim_clamped;
        bmpc_pkg::REG_IMAGE_HEIGHT:  h_r <= cfg_dim_clamped;
        bmpc_pkg::REG_PIXEL_MODE:    mode_r <= cfg_wdata[bmpc_pkg::MODE_W-1:0];
        bmpc_pkg::REG_ROWS_TOP_DOWN: top_down_r <= cfg_wdata[0];
        bmpc_pkg::REG_PALETTE_COUNT: pal_count_r <= cfg_wdata[bmpc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // stored row length in bytes, padded to four
  assign w_e = RS_W'(w_r);
  always_comb begin
    mode_ok = 1'b1;
    unique case (mode_r)
      bmpc_pkg::MODE_4BPP:  row_size = ((w_e + RS_W'(7)) >> 3) << 2;
      bmpc_pkg::MODE_8BPP:  row_size = ((w_e + RS_W'(3)) >> 2) << 2;
      bmpc_pkg::MODE_16BPP: row_size = (((w_e << 1) + RS_W'(3)) >> 2) << 2;
      bmpc_pkg::MODE_24BPP: row_size = ((w_e + (w_e << 1) + RS_W'(3)) >> 2) << 2;
      bmpc_pkg::MODE_32BPP: row_size = w_e << 2;
      default: begin
        row_size = '0;
        mode_ok  = 1'b0;
      end
    endcase
  end

  assign accept   = in_tvalid && in_tready;
  assign data_acc = accept && (in_tuser == bmpc_pkg::ACT_DATA);

  assign col_p1 = {1'b0, col_r} + (DIM_W + 1)'(1);
  assign w_m1   = w_r - DIM_W'(1);
  assign h_m1   = h_r - DIM_W'(1);
  assign y_dim  = top_down_r ? row_r : (h_m1 - row_r);
  assign bir_inc = {1'b0, bir_r} + (RS_W + 1)'(1);

  always_comb begin
    col_nxt    = col_r;
    bip_nxt    = bip_r;
    gather_nxt = gather_r;
    bir_nxt    = bir_r;
    row_nxt    = row_r;
    emit_a     = 1'b0;
    emit_b     = 1'b0;
    a_pal      = 1'b0;
    a_rgba     = bmpc_pkg::from_rgb(gather_r);
    idx_a      = in_byte;
    idx_b      = {4'h0, in_byte[3:0]};
    if (mode_ok) begin
      if (col_r < w_r) begin
        unique case (mode_r)
          bmpc_pkg::MODE_4BPP: begin
            emit_a  = 1'b1;
            a_pal   = 1'b1;
            idx_a   = {4'h0, in_byte[7:4]};
            emit_b  = col_p1 < {1'b0, w_r};
            col_nxt = col_r + (emit_b ? DIM_W'(2) : DIM_W'(1));
          end
          bmpc_pkg::MODE_8BPP: begin
            emit_a  = 1'b1;
            a_pal   = 1'b1;
            col_nxt = col_r + DIM_W'(1);
          end
          bmpc_pkg::MODE_16BPP: begin
            if (bip_r == 2'd0) begin
              gather_nxt = {16'h0, in_byte};
              bip_nxt    = 2'd1;
            end else begin
              emit_a       = 1'b1;
              a_rgba.red   = bmpc_pkg::widen5(in_byte[6:2]);
              a_rgba.green = bmpc_pkg::widen5({in_byte[1:0], gather_r[7:5]});
              a_rgba.blue  = bmpc_pkg::widen5(gather_r[4:0]);
              bip_nxt      = 2'd0;
              gather_nxt   = '0;
              col_nxt      = col_r + DIM_W'(1);
            end
          end
          default: begin
            // 24 and 32 bpp: gather B, G (, R), the final byte completes the pixel
            if ((mode_r == bmpc_pkg::MODE_24BPP && bip_r < 2'd2) ||
                (mode_r == bmpc_pkg::MODE_32BPP && bip_r < 2'd3)) begin
              unique case (bip_r)
                2'd0:    gather_nxt[7:0]   = in_byte;
                2'd1:    gather_nxt[15:8]  = in_byte;
                default: gather_nxt[23:16] = in_byte;
              endcase
              bip_nxt = bip_r + 2'd1;
            end else begin
              emit_a = 1'b1;
              if (mode_r == bmpc_pkg::MODE_24BPP) begin
                a_rgba.red = in_byte;
              end else begin
                a_rgba.alpha = in_byte;
              end
              bip_nxt    = 2'd0;
              gather_nxt = '0;
              col_nxt    = col_r + DIM_W'(1);
            end
          end
        endcase
      end
      if (bir_inc >= {1'b0, row_size}) begin
        bir_nxt    = '0;
        col_nxt    = '0;
        bip_nxt    = 2'd0;
        gather_nxt = '0;
        row_nxt    = ({1'b0, row_r} + (DIM_W + 1)'(1) >= {1'b0, h_r}) ? '0 :
                     row_r + DIM_W'(1);
      end else begin
        bir_nxt = bir_inc[RS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      col_r    <= '0;
      row_r    <= '0;
      bir_r    <= '0;
      bip_r    <= 2'd0;
      gather_r <= '0;
    end else if (data_acc) begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      bir_r    <= bir_nxt;
      bip_r    <= bip_nxt;
      gather_r <= gather_nxt;
    end
  end

  // palette memory
  assign cnt_eff = (pal_count_r > bmpc_pkg::COUNT_W'(PALETTE_DEPTH)) ?
                   bmpc_pkg::COUNT_W'(PALETTE_DEPTH) : pal_count_r;
  assign raddr_a = ({1'b0, idx_a} < cnt_eff) ? PAL_AW'(idx_a) : '0;
  assign raddr_b = ({1'b0, idx_b} < cnt_eff) ? PAL_AW'(idx_b) : '0;
  assign pal_we  = accept && (in_tuser == bmpc_pkg::ACT_PALETTE) &&
                   ({1'b0, in_slot} < bmpc_pkg::COUNT_W'(PALETTE_DEPTH));
  assign s1_load = data_acc && emit_a;

  bmpc_ram #(
    .WIDTH (bmpc_pkg::RGB_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .we      (pal_we),
    .waddr   (PAL_AW'(in_slot)),
    .wdata   (in_rgb),
    .re_a    (s1_load && a_pal),
    .raddr_a (raddr_a),
    .rdata_a (ram_a),
    .re_b    (s1_load && emit_b),
    .raddr_b (raddr_b),
    .rdata_b (ram_b)
  );

  // result holding stage, drained one pixel per cycle into the output register while it can accept
  assign s1_valid  = a_pend_r || b_pend_r;
  assign move      = s1_valid && (!out_v_r || out_tready);
  assign s1_free   = !s1_valid || (move && !(a_pend_r && b_pend_r));
  assign in_tready = s1_free;

  always_comb begin
    if (a_pend_r) begin
      mv_rgba = a_pal_r ? bmpc_pkg::from_rgb(ram_a) : a_rgba_r;
      mv_x    = a_x_r;
      mv_last = a_last_r;
    end else begin
      mv_rgba = bmpc_pkg::from_rgb(ram_b);
      mv_x    = b_x_r;
      mv_last = b_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_pend_r <= 1'b0;
      b_pend_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (s1_load) begin
        a_pend_r <= 1'b1;
        b_pend_r <= emit_b;
      end else if (move) begin
        if (a_pend_r) begin
          a_pend_r <= 1'b0;
        end else begin
          b_pend_r <= 1'b0;
        end
      end
      if (move) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      a_pal_r  <= a_pal;
      a_rgba_r <= a_rgba;
      a_x_r    <= XY_W'(col_r);
      b_x_r    <= XY_W'(col_p1);
      y_r      <= XY_W'(y_dim);
      a_last_r <= (col_r == w_m1) && (row_r == h_m1);
      b_last_r <= (col_p1 == {1'b0, w_m1}) && (row_r == h_m1);
    end
    if (move) begin
      out_data_r <= {4'h0, y_r, mv_x, mv_rgba};
      out_last_r <= mv_last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `BMPC_ASSERT_ALWAYS(a_row_in_range, row_r < h_r, "row count reached image height")
  `BMPC_ASSERT_ALWAYS(a_col_in_range, col_r <= w_r, "column count beyond image width")
  `BMPC_ASSERT_IMPLY(a_byte_in_row, mode_ok, bir_r < row_size, "row byte overrun")
  `BMPC_ASSERT_IMPLY(a_second_pixel_order, b_pend_r, a_pend_r || out_v_r, "pixel order lost")

endmodule
